[design/mort_pkg.sv]
// Shared types and constants for the multistage range offset translator.
// No dependencies; imported by every module of the block.
package mort_pkg;

    localparam int MAX_STAGES        = 8;
    localparam int WINDOWS_PER_STAGE = 64;
    localparam int VALUE_BITS        = 40;
    localparam int CFG_BITS          = 4;
    localparam int REQ_BITS          = 2;
    localparam int STAGE_BITS        = $clog2(MAX_STAGES);
    localparam int SLOT_BITS         = $clog2(WINDOWS_PER_STAGE);
    localparam int ADDR_BITS         = STAGE_BITS + SLOT_BITS;
    localparam int TABLE_DEPTH       = MAX_STAGES * WINDOWS_PER_STAGE;

    localparam logic [CFG_BITS-1:0]   STAGES_RESET = CFG_BITS'(MAX_STAGES);
    localparam logic [STAGE_BITS-1:0] STAGE_ZERO   = '0;
    localparam logic [SLOT_BITS-1:0]  SLOT_ZERO    = '0;
    localparam logic [SLOT_BITS-1:0]  SLOT_ONE     = SLOT_BITS'(1);
    localparam logic [SLOT_BITS-1:0]  SLOT_LAST    = SLOT_BITS'(WINDOWS_PER_STAGE - 1);
    localparam logic [ADDR_BITS-1:0]  ADDR_LAST    = ADDR_BITS'(TABLE_DEPTH - 1);
    localparam logic                  ONE_SLOT     = (WINDOWS_PER_STAGE == 1);

    typedef enum logic [REQ_BITS-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_XLATE  = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_UNUSED = 2'd3
    } t_req;

    // one table entry; delta is dest - source in two's complement
    typedef struct packed {
        logic                  valid;
        logic [VALUE_BITS-1:0] src;
        logic [VALUE_BITS:0]   win_end;
        logic [VALUE_BITS:0]   delta;
    } t_entry;

    typedef struct packed {
        logic                 wr_en;
        logic                 wr_clear;
        logic [ADDR_BITS-1:0] wr_addr;
        logic [ADDR_BITS-1:0] rd_addr;
        logic                 start;
        logic                 check;
        logic                 min_init;
        logic                 emit;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic out_free;
    } t_stat;

endpackage

[design/mort_if.sv]
// Valid/ready channel interfaces for request and result words.
// Depends on mort_pkg for field widths.
interface mort_in_if import mort_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [REQ_BITS-1:0]   req_type;
    logic [STAGE_BITS-1:0] stage_index;
    logic [SLOT_BITS-1:0]  slot_index;
    logic [VALUE_BITS-1:0] source_start;
    logic [VALUE_BITS-1:0] window_length;
    logic [VALUE_BITS-1:0] dest_start;
    logic [VALUE_BITS-1:0] lookup_value;

    modport source (
        output valid, req_type, stage_index, slot_index, source_start,
               window_length, dest_start, lookup_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, stage_index, slot_index, source_start,
               window_length, dest_start, lookup_value,
        output ready
    );
endinterface

interface mort_out_if import mort_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] translated_value;
    logic                  overflow;
    logic [VALUE_BITS-1:0] running_minimum;

    modport source (
        output valid, translated_value, overflow, running_minimum,
        input  ready
    );
    modport sink (
        input  valid, translated_value, overflow, running_minimum,
        output ready
    );
endinterface

[design/mort_ctrl.sv]
// Sequencer: table clear sweep, window loads, and the per-stage slot scan.
// Depends on mort_pkg; drives mort_dp through t_cmd, reads t_stat.
module mort_ctrl import mort_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_BITS-1:0]   i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic [REQ_BITS-1:0]   i_req_type,
    input  logic [STAGE_BITS-1:0] i_stage_index,
    input  logic [SLOT_BITS-1:0]  i_slot_index,
    output logic                  o_in_ready,
    input  t_stat                 i_stat,
    output t_cmd                  o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [CFG_BITS-1:0]   r_stages;
    logic [ADDR_BITS-1:0]  r_sweep, n_sweep;
    logic [STAGE_BITS-1:0] r_stage, n_stage;
    logic [SLOT_BITS-1:0]  r_slot, n_slot;
    logic                  r_pend_last, n_pend_last;

    logic [CFG_BITS-1:0]   stages_eff;
    logic [STAGE_BITS-1:0] last_stage;
    logic                  accept;
    logic                  load_ok;
    logic                  advance;

    assign stages_eff = (r_stages > STAGES_RESET) ? STAGES_RESET : r_stages;
    assign last_stage = STAGE_BITS'(stages_eff - CFG_BITS'(1));
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign load_ok    = (32'(i_stage_index) < MAX_STAGES) &&
                        (32'(i_slot_index) < WINDOWS_PER_STAGE);
    assign advance    = i_stat.hit || r_pend_last;

    always_comb begin
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_stage     = r_stage;
        n_slot      = r_slot;
        n_pend_last = r_pend_last;
        o_cmd       = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_clear = 1'b1;
                o_cmd.wr_addr  = r_sweep;
                n_sweep        = r_sweep + ADDR_BITS'(1);
                if (r_sweep == ADDR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (t_req'(i_req_type))
                        REQ_LOAD: begin
                            o_cmd.wr_en   = load_ok;
                            o_cmd.wr_addr = {i_stage_index, i_slot_index};
                        end
                        REQ_XLATE: begin
                            o_cmd.start = 1'b1;
                            if (stages_eff == '0) begin
                                n_state = S_EMIT;
                            end else begin
                                // first window read goes out with the accept
                                o_cmd.rd_addr = {STAGE_ZERO, SLOT_ZERO};
                                n_stage       = STAGE_ZERO;
                                n_slot        = SLOT_ONE;
                                n_pend_last   = ONE_SLOT;
                                n_state       = S_SCAN;
                            end
                        end
                        REQ_CLEAR: begin
                            o_cmd.min_init = 1'b1;
                            n_sweep        = '0;
                            n_state        = S_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.check = 1'b1;
                if (advance) begin
                    if (r_stage == last_stage) begin
                        n_state = S_EMIT;
                    end else begin
                        // drop the read in flight, restart at slot 0 of next stage
                        n_stage       = r_stage + STAGE_BITS'(1);
                        o_cmd.rd_addr = {n_stage, SLOT_ZERO};
                        n_slot        = SLOT_ONE;
                        n_pend_last   = ONE_SLOT;
                    end
                end else begin
                    o_cmd.rd_addr = {r_stage, r_slot};
                    n_pend_last   = (r_slot == SLOT_LAST);
                    n_slot        = r_slot + SLOT_ONE;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_stages    <= STAGES_RESET;
            r_stage     <= '0;
            r_slot      <= '0;
            r_pend_last <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_stage     <= n_stage;
            r_slot      <= n_slot;
            r_pend_last <= n_pend_last;
            if (i_cfg_we) begin
                r_stages <= i_cfg_wdata;
            end
        end
    end

endmodule

[design/mort_dp.sv]
// Datapath: window table memory, value/overflow/minimum registers, result register.
// Depends on mort_pkg; commanded by mort_ctrl.
module mort_dp import mort_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [VALUE_BITS-1:0] i_source_start,
    input  logic [VALUE_BITS-1:0] i_window_length,
    input  logic [VALUE_BITS-1:0] i_dest_start,
    input  logic [VALUE_BITS-1:0] i_lookup_value,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [VALUE_BITS-1:0] o_translated_value,
    output logic                  o_overflow,
    output logic [VALUE_BITS-1:0] o_running_minimum
);

    t_entry                mem [TABLE_DEPTH];
    t_entry                r_rd;
    t_entry                wdata;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_ovf;
    logic [VALUE_BITS-1:0] r_min;
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_value;
    logic                  r_out_ovf;
    logic [VALUE_BITS-1:0] r_out_min;

    logic [VALUE_BITS:0]   v_ext;
    logic [VALUE_BITS:0]   sum;
    logic [VALUE_BITS-1:0] new_min;

    always_comb begin
        wdata.valid   = !i_cmd.wr_clear;
        wdata.src     = i_source_start;
        wdata.win_end = {1'b0, i_source_start} + {1'b0, i_window_length};
        wdata.delta   = {1'b0, i_dest_start} - {1'b0, i_source_start};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_cmd.wr_addr] <= wdata;
        end
        r_rd <= mem[i_cmd.rd_addr];
    end

    // a hit value is at least src, so the sum never goes negative
    assign v_ext      = {1'b0, r_value};
    assign sum        = v_ext + r_rd.delta;
    assign o_stat.hit = r_rd.valid && (r_value >= r_rd.src) && (v_ext < r_rd.win_end);
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign new_min    = (r_value < r_min) ? r_value : r_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= '1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.min_init) begin
                r_min <= '1;
            end else if (i_cmd.emit) begin
                r_min <= new_min;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_value <= i_lookup_value;
            r_ovf   <= 1'b0;
        end else if (i_cmd.check && o_stat.hit) begin
            r_value <= sum[VALUE_BITS] ? '1 : sum[VALUE_BITS-1:0];
            r_ovf   <= r_ovf | sum[VALUE_BITS];
        end
        if (i_cmd.emit) begin
            r_out_value <= r_value;
            r_out_ovf   <= r_ovf;
            r_out_min   <= new_min;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_translated_value = r_out_value;
    assign o_overflow         = r_out_ovf;
    assign o_running_minimum  = r_out_min;

endmodule

[design/multistage_range_offset_translator_unit.sv]
// Top level of the multistage range offset translator.
// Depends on mort_pkg, mort_if, mort_ctrl and mort_dp.
//
// Usage:
//  - i_in carries request words: load a window (stage, slot, source, length,
//    dest), translate a lookup value, or clear the table and running minimum.
//  - o_out carries one result word per translate: translated value,
//    overflow flag and running minimum. Loads and clears give no word.
//  - i_cfg_we/i_cfg_wdata write stages_in_use (values above 8 act as 8);
//    write it only while the block is idle.
//  - Load: the entry is written as the request is accepted. Clear: one
//    table entry erased per cycle. Translate: after the accept, per stage
//    in use the slots are read in order up to and including the first
//    matching slot (64 if none), then the result is posted. The window
//    table has a single read port, so slots are read one at a time.
//  - One request is in progress at a time; a new one is taken as soon as the
//    previous one has posted, even if its result word still waits.
//  - Reset: a sweep of the whole table invalidates it; i_in.ready stays low
//    during it. stages_in_use returns to 8, running minimum to all ones.
//  - Receiver stall: the result register holds its word; a finished
//    translate then waits before posting, and i_in.ready stays low.
module multistage_range_offset_translator_unit import mort_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_BITS-1:0] i_cfg_wdata,
    mort_in_if.sink             i_in,
    mort_out_if.source          o_out
);

    t_cmd  cmd;   // sequencer to datapath
    t_stat stat;  // datapath to sequencer

    mort_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in.valid),
        .i_req_type    (i_in.req_type),
        .i_stage_index (i_in.stage_index),
        .i_slot_index  (i_in.slot_index),
        .o_in_ready    (i_in.ready),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    mort_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_source_start     (i_in.source_start),
        .i_window_length    (i_in.window_length),
        .i_dest_start       (i_in.dest_start),
        .i_lookup_value     (i_in.lookup_value),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_translated_value (o_out.translated_value),
        .o_overflow         (o_out.overflow),
        .o_running_minimum  (o_out.running_minimum)
    );

endmodule
